// ===== hdl/fcg_pkg.sv =====
// Shared types, constants and blend helpers for the four-corner gradient color block.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package fcg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = FRAC_BITS + 1;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int COLOR_W   = CHAN_W * NUM_CHAN;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int DIFF_W    = CHAN_W + 1;
   localparam int PROD_W    = DIFF_W + POS_W + 1;
   localparam int SH_W      = PROD_W - FRAC_BITS;

   localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR0 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR1 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR2 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR3 = CSR_IDX_W'(4);

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_array_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_CHAN-1:0][PROD_W-1:0] prod_array_type;

   typedef struct packed {
      color_type tl;
      color_type tr;
      color_type bl;
      color_type br;
   } corner_type;

   // Channel k of a packed color; k = 0 is red.
   function automatic logic [CHAN_W-1:0] chan_of(color_type c, int k);
      return c[(NUM_CHAN - 1 - k) * CHAN_W +: CHAN_W];
   endfunction

   // (b - a) * t, the part of a*(S-t) + b*t that is not a multiple of S.
   function automatic prod_type lerp_mul(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                         pos_type t);
      logic signed [DIFF_W-1:0] diff;
      logic signed [POS_W:0]    ts;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      ts   = $signed({1'b0, t});
      return diff * ts;
   endfunction

   // a + floor(p / S); the true result always lies in 0..255.
   function automatic logic [CHAN_W-1:0] lerp_add(logic [CHAN_W-1:0] a, prod_type p);
      logic signed [SH_W-1:0] sh;
      logic signed [SH_W-1:0] sum;
      sh  = p[PROD_W-1:FRAC_BITS];
      sum = SH_W'($signed({1'b0, a})) + sh;
      return sum[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/fcg_csr.sv =====
// Configuration registers and the corner mapping chosen by the color count.
// Depends on fcg_pkg.
`default_nettype none

module fcg_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fcg_pkg::COLOR_W-1:0]    csr_data,
   output fcg_pkg::corner_type                 corners
);
   import fcg_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   color_type          color0_ff;
   color_type          color1_ff;
   color_type          color2_ff;
   color_type          color3_ff;
   logic               write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_W'(1);
         color0_ff <= '0;
         color1_ff <= '0;
         color2_ff <= '0;
         color3_ff <= '0;
      end else if (write) begin
         unique case (csr_index)
            CSR_COUNT:  count_ff  <= csr_data[COUNT_W-1:0];
            CSR_COLOR0: color0_ff <= csr_data;
            CSR_COLOR1: color1_ff <= csr_data;
            CSR_COLOR2: color2_ff <= csr_data;
            CSR_COLOR3: color3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // A count of zero acts as one, and anything above four acts as four.
   always_comb begin
      corners.tl = color0_ff;
      unique case (count_ff)
         COUNT_W'(2): begin
            corners.tr = color0_ff;
            corners.bl = color1_ff;
            corners.br = color1_ff;
         end
         COUNT_W'(3): begin
            corners.tr = color1_ff;
            corners.bl = color2_ff;
            corners.br = color2_ff;
         end
         COUNT_W'(0), COUNT_W'(1): begin
            corners.tr = color0_ff;
            corners.bl = color0_ff;
            corners.br = color0_ff;
         end
         default: begin
            corners.tr = color1_ff;
            corners.bl = color3_ff;
            corners.br = color2_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/fcg_hblend.sv =====
// Horizontal blend of the top and bottom rows by u: a multiply stage, then an add stage.
// Depends on fcg_pkg; the vertical position rides along for the next unit.
`default_nettype none

module fcg_hblend (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire fcg_pkg::pos_type        in_u,
   input  wire fcg_pkg::pos_type        in_v,
   input  wire fcg_pkg::corner_type     corners,
   output logic                         out_valid,
   output fcg_pkg::pos_type             out_v,
   output fcg_pkg::chan_array_type      out_top,
   output fcg_pkg::chan_array_type      out_bot
);
   import fcg_pkg::*;

   logic           mul_valid_ff;
   pos_type        mul_v_ff;
   prod_array_type top_prod_ff;
   prod_array_type bot_prod_ff;
   chan_array_type top_left_ff;
   chan_array_type bot_left_ff;

   logic           add_valid_ff;
   pos_type        add_v_ff;
   chan_array_type top_ff;
   chan_array_type bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_v_ff <= in_v;
      add_v_ff <= mul_v_ff;
      for (int k = 0; k < NUM_CHAN; k++) begin
         top_left_ff[k] <= chan_of(corners.tl, k);
         bot_left_ff[k] <= chan_of(corners.bl, k);
         top_prod_ff[k] <= lerp_mul(chan_of(corners.tl, k), chan_of(corners.tr, k), in_u);
         bot_prod_ff[k] <= lerp_mul(chan_of(corners.bl, k), chan_of(corners.br, k), in_u);
         top_ff[k]      <= lerp_add(top_left_ff[k], top_prod_ff[k]);
         bot_ff[k]      <= lerp_add(bot_left_ff[k], bot_prod_ff[k]);
      end
   end

   assign out_valid = add_valid_ff;
   assign out_v     = add_v_ff;
   assign out_top   = top_ff;
   assign out_bot   = bot_ff;

endmodule

`default_nettype wire

// ===== hdl/fcg_vblend.sv =====
// Vertical blend of the two row values by v: a multiply stage, then the result register.
// Depends on fcg_pkg.
`default_nettype none

module fcg_vblend (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire fcg_pkg::pos_type        in_v,
   input  wire fcg_pkg::chan_array_type in_top,
   input  wire fcg_pkg::chan_array_type in_bot,
   output logic                         out_valid,
   output fcg_pkg::chan_array_type      out_color
);
   import fcg_pkg::*;

   logic           mul_valid_ff;
   prod_array_type prod_ff;
   chan_array_type top_ff;
   logic           res_valid_ff;
   chan_array_type res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         top_ff[k]  <= in_top[k];
         prod_ff[k] <= lerp_mul(in_top[k], in_bot[k], in_v);
         res_ff[k]  <= lerp_add(top_ff[k], prod_ff[k]);
      end
   end

   assign out_valid = res_valid_ff;
   assign out_color = res_ff;

endmodule

`default_nettype wire

// ===== hdl/four_corner_gradient_color.sv =====
// Top level of the four-corner gradient color block: input stage, blend pipeline, registers.
// Depends on fcg_pkg, fcg_csr, fcg_hblend and fcg_vblend.
`default_nettype none

// A request (pos_u, pos_v in Q1.16, values above 1.0 clamp to 1.0) is taken on any
// cycle with start high; busy never rises, so one request per clock is sustained.
// Each request gives one color, shown for a single cycle with rsp_strobe high, through
// one input register plus two multiply/add pairs, one for the horizontal and one for the
// vertical blend. The receiver cannot stall the output, so results must be taken when the
// strobe is high. The user must write the color registers through the csr port only while
// no request is in flight; the block itself does not enforce this.
module four_corner_gradient_color (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [fcg_pkg::POS_W-1:0]     req_pos_u,
   input  wire logic [fcg_pkg::POS_W-1:0]     req_pos_v,
   output logic                               rsp_strobe,
   output logic [fcg_pkg::CHAN_W-1:0]         rsp_red,
   output logic [fcg_pkg::CHAN_W-1:0]         rsp_green,
   output logic [fcg_pkg::CHAN_W-1:0]         rsp_blue,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fcg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fcg_pkg::COLOR_W-1:0]   csr_data
);
   import fcg_pkg::*;

   corner_type     corners;
   logic           in_valid_ff;
   pos_type        u_ff;
   pos_type        v_ff;
   logic           h_valid;
   pos_type        h_v;
   chan_array_type h_top;
   chan_array_type h_bot;
   logic           v_valid;
   chan_array_type color;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= (req_pos_u > ONE_POS) ? ONE_POS : req_pos_u;
      v_ff <= (req_pos_v > ONE_POS) ? ONE_POS : req_pos_v;
   end

   fcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .corners   (corners)
   );

   fcg_hblend u_hblend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_u      (u_ff),
      .in_v      (v_ff),
      .corners   (corners),
      .out_valid (h_valid),
      .out_v     (h_v),
      .out_top   (h_top),
      .out_bot   (h_bot)
   );

   fcg_vblend u_vblend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_valid),
      .in_v      (h_v),
      .in_top    (h_top),
      .in_bot    (h_bot),
      .out_valid (v_valid),
      .out_color (color)
   );

   assign rsp_strobe = v_valid;
   assign rsp_red    = color[0];
   assign rsp_green  = color[1];
   assign rsp_blue   = color[2];

endmodule

`default_nettype wire
